// File: design/wmtm_pkg.sv
// ----------------------------------------------------------------------------
// wmtm_pkg: shared types and constants for the warp marker time map
// positions, codes, table sizes and sequencer states
// ----------------------------------------------------------------------------
package wmtm_pkg;

  localparam int MaxMarkers = 32;
  localparam int FracBits   = 8;
  localparam int PosW       = 32 + FracBits;
  localparam int IdxW       = $clog2(MaxMarkers);
  localparam int CntW       = 6;
  localparam int QDepth     = 2;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_S2B   = 2'd1,
    MODE_B2S   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOPAIR = 2'd3
  } status_t;

  // classified request passed from front to back
  typedef struct packed {
    mode_t mode;
    pos_t  s;
    pos_t  b;
    logic  s_over;   // add sample beyond clip end
    pos_t  clip_end;
  } req_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SCAN_LAST,
    BK_DECIDE,
    BK_DIV,
    BK_WRITE,
    BK_CLR_B,
    BK_OUT
  } bk_state_t;

endpackage

// File: design/wmtm_if.sv
// ----------------------------------------------------------------------------
// wmtm_req_if / wmtm_rsp_if / wmtm_cfg_if: valid-ready channels
// request, result and configuration channels of the time map
// ----------------------------------------------------------------------------
interface wmtm_req_if;
  import wmtm_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  pos_t       sample_pos;
  pos_t       beat_pos;
  modport source (output valid, mode, sample_pos, beat_pos, input ready);
  modport sink   (input valid, mode, sample_pos, beat_pos, output ready);
endinterface

interface wmtm_rsp_if;
  import wmtm_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  pos_t       mapped_pos;
  cnt_t       marker_count;
  modport source (output valid, status, mapped_pos, marker_count, input ready);
  modport sink   (input valid, status, mapped_pos, marker_count, output ready);
endinterface

interface wmtm_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: design/wmtm_ram.sv
// ----------------------------------------------------------------------------
// wmtm_ram: generic single-port-write ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module wmtm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/wmtm_front.sv
// ----------------------------------------------------------------------------
// wmtm_front: request intake and classification
// checks the clip bound, forms the clip end, and queues the request
// ----------------------------------------------------------------------------
module wmtm_front
  import wmtm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  wmtm_req_if.sink          req,
  input  logic [31:0]       clip_length,
  output logic              q_valid,
  output req_t              q_head,
  input  logic              q_pop
);
  req_t                  slots [QDepth];
  logic [$clog2(QDepth)-1:0] wp, rp;
  logic [$clog2(QDepth):0]   fill;
  req_t                  cur;
  pos_t                  clip_end;
  logic                  push;

  assign clip_end = {clip_length, {FracBits{1'b0}}};
  assign req.ready = (fill != QDepth[$clog2(QDepth):0]);
  assign push = req.valid && req.ready;

  always_comb begin
    cur.mode     = mode_t'(req.mode);
    cur.s        = req.sample_pos;
    cur.b        = req.beat_pos;
    cur.s_over   = req.sample_pos > clip_end;
    cur.clip_end = clip_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (q_pop) rp <= rp + 1'b1;
      fill <= fill + {{$clog2(QDepth){1'b0}}, push} - {{$clog2(QDepth){1'b0}}, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= cur;
  end

  assign q_valid = (fill != '0);
  assign q_head  = slots[rp];
endmodule

// File: design/wmtm_muldiv.sv
// ----------------------------------------------------------------------------
// wmtm_muldiv: bit-serial floor(a*b/c)
// one multiplier bit per cycle, a < c assumed
// ----------------------------------------------------------------------------
module wmtm_muldiv
  import wmtm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  pos_t a,
  input  pos_t b,
  input  pos_t c,
  output logic done,
  output pos_t q
);
  localparam int StW = $clog2(PosW + 1);
  pos_t            ra, rb, rc;
  logic [PosW:0]   r;
  logic [StW-1:0]  left;
  logic            busy;
  logic [PosW+1:0] t1, t2;
  logic [PosW+1:0] d1, d2;
  logic [PosW:0]   r1;
  logic            q1, q2;

  always_comb begin
    t1 = {r, 1'b0};
    q1 = t1 >= {2'b0, rc};
    d1 = t1 - {2'b0, rc};
    r1 = q1 ? d1[PosW:0] : t1[PosW:0];
    t2 = {1'b0, r1} + (rb[PosW-1] ? {2'b0, ra} : '0);
    q2 = t2 >= {2'b0, rc};
    d2 = t2 - {2'b0, rc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; left <= StW'(PosW);
        ra <= a; rb <= b; rc <= c; r <= '0; q <= '0;
      end else if (busy) begin
        r  <= q2 ? d2[PosW:0] : t2[PosW:0];
        q  <= {q[PosW-2:0], 1'b0} + pos_t'(q1) + pos_t'(q2);
        rb <= {rb[PosW-2:0], 1'b0};
        left <= left - 1'b1;
        if (left == StW'(1)) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: design/wmtm_back.sv
// ----------------------------------------------------------------------------
// wmtm_back: marker table sequencer
// scans the tables for bounding pairs, edits the table, runs interpolation
// ----------------------------------------------------------------------------
module wmtm_back
  import wmtm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  req_t     q_head,
  output logic     q_pop,
  wmtm_rsp_if.source rsp
);
  bk_state_t st, st_next;
  req_t   r;
  cnt_t   total;
  idx_t   ridx;
  idx_t   sidx;              // index of row being compared
  logic   clr_phase;         // clear: second marker pending
  logic   dup;
  logic   hs_lo, hs_hi, hb_lo, hb_hi;
  idx_t   s_lo, s_hi, b_lo, b_hi;
  pos_t   sv_lo, sv_hi, bv_lo, bv_hi;     // key values of bounds
  pos_t   sx_lo, sx_hi, bx_lo, bx_hi;     // other-table values at bounds
  pos_t   s_rd, b_rd;
  logic   we;
  status_t res_st;
  pos_t   res_pos;
  logic   mstart, mdone;
  pos_t   ma, mb, mc, mq;
  logic   md_down;
  pos_t   md_base;
  logic   out_full;
  status_t o_st; pos_t o_pos; cnt_t o_cnt;

  wmtm_ram #(.Width(PosW), .Depth(MaxMarkers)) u_sram (
    .clk, .we, .waddr(total[IdxW-1:0]), .wdata(r.s), .raddr(ridx), .rdata(s_rd));
  wmtm_ram #(.Width(PosW), .Depth(MaxMarkers)) u_bram (
    .clk, .we, .waddr(total[IdxW-1:0]), .wdata(r.b), .raddr(ridx), .rdata(b_rd));

  wmtm_muldiv u_md (.clk, .rst, .start(mstart), .a(ma), .b(mb), .c(mc),
    .done(mdone), .q(mq));

  assign we = (st == BK_WRITE);
  assign q_pop = (st == BK_IDLE) && q_valid && !out_full;

  always_comb begin
    st_next = st;
    unique case (st)
      BK_IDLE:      if (q_pop) st_next = (q_head.mode == MODE_CLEAR) ? BK_CLR_B :
                                      (total == '0) ? BK_DECIDE : BK_SCAN;
      BK_SCAN:      if (ridx == idx_t'(total - 1'b1) || total == cnt_t'(1))
                      st_next = BK_SCAN_LAST;
      BK_SCAN_LAST: st_next = BK_DECIDE;
      BK_DECIDE:    st_next = (res_st == ST_DONE &&
                               (r.mode == MODE_ADD || r.mode == MODE_CLEAR)) ? BK_WRITE :
                              (res_st == ST_DONE) ? BK_DIV : BK_OUT;
      BK_DIV:       if (mdone) st_next = BK_OUT;
      BK_WRITE:     st_next = clr_phase ? BK_SCAN : BK_OUT;
      BK_CLR_B:     st_next = BK_DECIDE;
      BK_OUT:       st_next = BK_IDLE;
      default:      st_next = BK_IDLE;
    endcase
  end

  // decision from gathered bounds
  always_comb begin
    res_st = ST_DONE;
    ma = '0; mb = '0; mc = '1; md_down = 1'b0; md_base = '0;
    case (r.mode) inside
      MODE_ADD, MODE_CLEAR: begin
        if (r.s_over && r.mode == MODE_ADD) res_st = ST_REJECT;
        else if (total != '0) begin
          if (dup) res_st = ST_REJECT;
          else if (total >= cnt_t'(MaxMarkers)) res_st = ST_FULL;
          else if (total >= cnt_t'(2) && hs_lo && hs_hi) begin
            if (!(total >= cnt_t'(2) && hb_lo && hb_hi)) res_st = ST_REJECT;
            else if (b_lo != s_lo || b_hi != s_hi) res_st = ST_REJECT;
            else if (r.s == sv_lo || r.s == sv_hi || r.b == bv_lo || r.b == bv_hi)
              res_st = ST_REJECT;
          end
        end
      end
      MODE_S2B: begin
        if (!(total >= cnt_t'(2) && hs_lo && hs_hi)) res_st = ST_NOPAIR;
        ma = r.s - sv_lo; mc = sv_hi - sv_lo;
        md_down = sx_hi < sx_lo; md_base = sx_lo;
        mb = md_down ? sx_lo - sx_hi : sx_hi - sx_lo;
      end
      default: begin
        if (!(total >= cnt_t'(2) && hb_lo && hb_hi)) res_st = ST_NOPAIR;
        ma = r.b - bv_lo; mc = bv_hi - bv_lo;
        md_down = bx_hi < bx_lo; md_base = bx_lo;
        mb = md_down ? bx_lo - bx_hi : bx_hi - bx_lo;
      end
    endcase
  end
  assign mstart = (st == BK_DECIDE) && res_st == ST_DONE && r.mode != MODE_ADD
                  && r.mode != MODE_CLEAR;

  // read data is registered and arrives in the cycle after its address
  logic cmp_ok;
  assign cmp_ok = (st == BK_SCAN && ridx != '0) || st == BK_SCAN_LAST;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_IDLE; total <= '0; out_full <= 1'b0; clr_phase <= 1'b0;
    end else begin
      st <= st_next;
      if (rsp.valid && rsp.ready) out_full <= 1'b0;
      if (st == BK_WRITE) total <= total + 1'b1;
      if (st == BK_IDLE && q_pop && q_head.mode == MODE_CLEAR) begin
        total <= '0; clr_phase <= 1'b1;
      end
      if (st == BK_DECIDE && r.mode == MODE_CLEAR && !(clr_phase && res_st == ST_DONE))
        clr_phase <= 1'b0;
      if (st == BK_DECIDE && r.mode == MODE_CLEAR && clr_phase && res_st == ST_DONE
          && total != '0) clr_phase <= 1'b0;
      if (st == BK_OUT) out_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st == BK_IDLE && q_pop) begin
      r <= q_head;
      if (q_head.mode == MODE_CLEAR) begin
        r.s <= '0; r.b <= '0;
      end
    end
    if (st == BK_WRITE && clr_phase) begin
      r.s <= r.clip_end; r.b <= r.clip_end;
    end
    if ((st == BK_IDLE && q_pop) || (st == BK_WRITE && clr_phase)) begin
      ridx <= '0; sidx <= '0; dup <= 1'b0;
      hs_lo <= 1'b0; hs_hi <= 1'b0; hb_lo <= 1'b0; hb_hi <= 1'b0;
    end else if (st == BK_SCAN) begin
      ridx <= ridx + 1'b1;
    end
    if (cmp_ok) begin
      sidx <= sidx + 1'b1;
      if (s_rd == r.s || b_rd == r.b) dup <= 1'b1;
      if (s_rd <= r.s) begin
        if (!hs_lo || s_rd > sv_lo) begin hs_lo <= 1'b1; s_lo <= sidx; sv_lo <= s_rd; sx_lo <= b_rd; end
      end else if (!hs_hi || s_rd < sv_hi) begin
        hs_hi <= 1'b1; s_hi <= sidx; sv_hi <= s_rd; sx_hi <= b_rd;
      end
      if (b_rd <= r.b) begin
        if (!hb_lo || b_rd > bv_lo) begin hb_lo <= 1'b1; b_lo <= sidx; bv_lo <= b_rd; bx_lo <= s_rd; end
      end else if (!hb_hi || b_rd < bv_hi) begin
        hb_hi <= 1'b1; b_hi <= sidx; bv_hi <= b_rd; bx_hi <= s_rd;
      end
    end
    if (st == BK_DECIDE) begin
      res_pos <= '0;
      o_st <= res_st;
    end
    if (st == BK_DIV && mdone) res_pos <= md_down ? md_base - mq : md_base + mq;
    if (st == BK_OUT) begin
      o_pos <= (o_st == ST_DONE) ? res_pos : '0;
      o_cnt <= total;
    end
  end

  assign rsp.valid        = out_full;
  assign rsp.status       = o_st;
  assign rsp.mapped_pos   = o_pos;
  assign rsp.marker_count = o_cnt;
endmodule

// File: design/warp_marker_time_map.sv
// ----------------------------------------------------------------------------
// warp_marker_time_map: piecewise linear warp marker map
// sorted-by-search marker table with add, clear and two interpolating lookups
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  req      in   mode, sample_pos, beat_pos
//  rsp      out  status, mapped_pos, marker_count
//  cfg      in   clip_length write data
//
// an add goes from pop to result through intake, one ram read per marker,
// a last compare, decide and write; an empty table skips the reads and compare
// a lookup runs the bit-serial multiply-divide in place of the write;
// a lookup without a pair skips the divide
// clear scans only the first default marker
// rst is synchronous; marker rams are not cleared, the count guards them
// a two-entry queue lets intake continue while the back end or rsp stalls
module warp_marker_time_map
  import wmtm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  wmtm_req_if.sink   req,
  wmtm_rsp_if.source rsp,
  wmtm_cfg_if.sink   cfg
);
  logic [31:0] clip_length;
  logic        q_valid, q_pop;
  req_t        q_head;

  // config register, always writable
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) clip_length <= '0;
    else if (cfg.valid) clip_length <= cfg.data;
  end

  wmtm_front u_front (.clk, .rst, .req, .clip_length, .q_valid, .q_head, .q_pop);
  wmtm_back  u_back  (.clk, .rst, .q_valid, .q_head, .q_pop, .rsp);

  // count never exceeds table size
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.marker_count <= cnt_t'(MaxMarkers))
    else $error("marker count beyond table");
  // failed requests carry zero position
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_DONE) |-> rsp.mapped_pos == '0)
    else $error("nonzero position on failure");
endmodule

// File: tb/tb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checker: marker map predictor and result comparator
// mirrors the marker table from accepted requests and checks every result
// ----------------------------------------------------------------------------
module tb_checker
  import wmtm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  wmtm_req_if   req,
  wmtm_rsp_if   rsp,
  wmtm_cfg_if   cfg,
  output int    fail_count,
  output int    pending,
  output int    rsp_total
);

  typedef struct {
    status_t st;
    pos_t    pos;
    cnt_t    cnt;
  } map_result_t;

  map_result_t expected_q[$];
  logic [31:0] clip_len;
  pos_t        m_samp [MaxMarkers];
  pos_t        m_beat [MaxMarkers];
  int          m_num;

  // bounding pair search over one key table
  function automatic bit bound_pair(input bit by_beat, input pos_t q,
                                    output int lo, output int hi);
    bit hl, hh;
    pos_t k;
    hl = 0; hh = 0; lo = 0; hi = 0;
    if (m_num < 2) return 0;
    for (int i = 0; i < m_num; i++) begin
      k = by_beat ? m_beat[i] : m_samp[i];
      if (k <= q) begin
        if (!hl || k > (by_beat ? m_beat[lo] : m_samp[lo])) begin lo = i; hl = 1; end
      end else begin
        if (!hh || k < (by_beat ? m_beat[hi] : m_samp[hi])) begin hi = i; hh = 1; end
      end
    end
    return hl && hh;
  endfunction

  function automatic pos_t lerp(input pos_t q, input pos_t qlo, input pos_t qhi,
                                input pos_t vlo, input pos_t vhi);
    logic [PosW*2-1:0] prod;
    pos_t num, den;
    num = q - qlo;
    den = qhi - qlo;
    if (vhi >= vlo) begin
      prod = num * (vhi - vlo);
      return vlo + pos_t'(prod / den);
    end
    prod = num * (vlo - vhi);
    return vlo - pos_t'(prod / den);
  endfunction

  function automatic status_t insert_marker(input pos_t s, input pos_t b);
    int slo, shi, blo, bhi;
    pos_t clip_end;
    clip_end = pos_t'(clip_len) << FracBits;
    if (s > clip_end) return ST_REJECT;
    if (m_num != 0) begin
      for (int i = 0; i < m_num; i++)
        if (m_samp[i] == s || m_beat[i] == b) return ST_REJECT;
      if (m_num >= MaxMarkers) return ST_FULL;
      if (bound_pair(0, s, slo, shi)) begin
        if (!bound_pair(1, b, blo, bhi)) return ST_REJECT;
        if (blo != slo || bhi != shi) return ST_REJECT;
        if (s == m_samp[slo] || s == m_samp[shi] ||
            b == m_beat[slo] || b == m_beat[shi]) return ST_REJECT;
      end
    end
    m_samp[m_num] = s;
    m_beat[m_num] = b;
    m_num++;
    return ST_DONE;
  endfunction

  function automatic map_result_t apply_request(input mode_t md, input pos_t s,
                                                input pos_t b);
    map_result_t r;
    int lo, hi;
    pos_t e;
    r.st = ST_DONE; r.pos = '0;
    case (md)
      MODE_ADD: r.st = insert_marker(s, b);
      MODE_S2B: begin
        if (bound_pair(0, s, lo, hi))
          r.pos = lerp(s, m_samp[lo], m_samp[hi], m_beat[lo], m_beat[hi]);
        else r.st = ST_NOPAIR;
      end
      MODE_B2S: begin
        if (bound_pair(1, b, lo, hi))
          r.pos = lerp(b, m_beat[lo], m_beat[hi], m_samp[lo], m_samp[hi]);
        else r.st = ST_NOPAIR;
      end
      default: begin
        e = pos_t'(clip_len) << FracBits;
        m_num = 0;
        r.st = insert_marker('0, '0);
        if (r.st == ST_DONE) r.st = insert_marker(e, e);
      end
    endcase
    r.cnt = cnt_t'(m_num);
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("error @%0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    map_result_t w;
    if (rst) begin
      clip_len   <= '0;
      m_num       = 0;
      fail_count  = 0;
      rsp_total   = 0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) clip_len <= cfg.data;
      if (rsp.valid && rsp.ready) begin
        rsp_total++;
        if (expected_q.size() == 0) report("unexpected result", 0, 0);
        else begin
          w = expected_q.pop_front();
          if (rsp.status !== w.st) report("status", rsp.status, w.st);
          if (rsp.mapped_pos !== w.pos) report("mapped_pos", rsp.mapped_pos, w.pos);
          if (rsp.marker_count !== w.cnt) report("marker_count", rsp.marker_count, w.cnt);
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(apply_request(mode_t'(req.mode), req.sample_pos,
                                           req.beat_pos));
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the warp marker time map
// directed edge cases, then random marker builds and lookups with random gaps
// ----------------------------------------------------------------------------
module tb_top;
  import wmtm_pkg::*;

  localparam int WatchLimit = 20000;

  logic clk;
  logic rst;
  int   fail_count, pending, rsp_total;
  int   idle_cycles;
  int   req_total;

  wmtm_req_if req ();
  wmtm_rsp_if rsp ();
  wmtm_cfg_if cfg ();

  warp_marker_time_map u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  tb_checker u_chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                    .fail_count(fail_count), .pending(pending), .rsp_total(rsp_total));

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // gap length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic pos_t rnd_pos();
    return pos_t'({$urandom, $urandom});
  endfunction

  // result side stalls at random
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 40) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(10, 80)) @(posedge clk);
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(0, 3) != 0);
      end
      @(posedge clk);
    end
  end

  // watchdog: cycles in which nothing is accepted
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("warp_marker_time_map: mismatch");
      $finish;
    end
  end

  // send one request and hold it until accepted; valid stays up for a
  // following request with no gap
  task automatic send_req(input mode_t md, input pos_t s, input pos_t b);
    int g;
    g = gap_len();
    if (g != 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.mode       <= md;
    req.sample_pos <= s;
    req.beat_pos   <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    req_total++;
  endtask

  // stop sending and wait until every expected result is back
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // wait for the block to drain, then write clip length
  task automatic write_clip(input logic [31:0] v);
    drain();
    repeat (200) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // a build: clear, then markers with beats near their samples or random, then lookups
  task automatic build_and_query(input logic [31:0] clip, input int nmark, input int nq);
    pos_t e, s, b;
    int   k;
    write_clip(clip);
    send_req(MODE_CLEAR, rnd_pos(), rnd_pos());
    e = pos_t'(clip) << FracBits;
    for (k = 0; k < nmark; k++) begin
      s = pos_t'({$urandom, $urandom}) % (e + 1);
      b = (e == 0) ? pos_t'(0) : pos_t'(s + $urandom_range(0, 300) - 150);
      if ($urandom_range(0, 4) == 0) b = rnd_pos();
      send_req(MODE_ADD, s, b);
    end
    for (k = 0; k < nq; k++) begin
      s = ($urandom_range(0, 9) == 0) ? rnd_pos() : pos_t'({$urandom, $urandom}) % (e + 2);
      b = ($urandom_range(0, 9) == 0) ? rnd_pos() : pos_t'({$urandom, $urandom}) % (e + 2);
      send_req($urandom_range(0, 1) ? MODE_S2B : MODE_B2S, s, b);
    end
  endtask

  initial begin
    logic [31:0] clip;
    pos_t        top;
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.mode  <= MODE_ADD;
    req.sample_pos <= '0;
    req.beat_pos   <= '0;
    cfg.valid <= 1'b0;
    cfg.data  <= '0;
    req_total = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table lookups, clear with zero clip length
    top = {PosW{1'b1}};
    send_req(MODE_S2B, '0, '0);
    send_req(MODE_B2S, top, top);
    send_req(MODE_ADD, '0, top);          // add to empty table
    send_req(MODE_ADD, '0, '0);           // duplicate
    send_req(MODE_CLEAR, '0, '0);         // second default is a duplicate
    send_req(MODE_S2B, '0, '0);

    // directed: widest clip, defaults, edge and interior adds
    write_clip(32'hFFFF_FFFF);
    send_req(MODE_CLEAR, top, top);
    top = pos_t'(32'hFFFF_FFFF) << FracBits;
    send_req(MODE_ADD, top + 1, 40'd5);   // beyond clip end
    send_req(MODE_ADD, top, 40'd5);       // duplicate sample at end
    send_req(MODE_ADD, 40'h10_0000_0000, 40'h20_0000_0000);
    send_req(MODE_ADD, 40'h20_0000_0000, 40'h10_0000_0000); // crossing pair
    send_req(MODE_ADD, 40'h30_0000_0000, 40'h30_0000_0000);
    send_req(MODE_S2B, 40'h08_0000_0001, '0);
    send_req(MODE_B2S, '0, 40'h28_0000_0003);
    send_req(MODE_S2B, top, '0);          // at the top end: no high marker
    send_req(MODE_B2S, '0, {PosW{1'b1}});
    send_req(MODE_S2B, '0, '0);
    // fill the table to full with a rising run past the last interior marker
    for (int k = 0; k < 32; k++)
      send_req(MODE_ADD, 40'h40_0000_0000 + k * 40'h100, 40'h40_0000_0000 + k * 40'h101);

    // hold off until every result is back
    drain();

    // random: builds at many clip lengths, mostly small tables
    while (req_total < 1000) begin
      case ($urandom_range(0, 5))
        0:       clip = 32'd0;
        1:       clip = 32'hFFFF_FFFF;
        2:       clip = $urandom_range(1, 4);
        default: clip = $urandom;
      endcase
      build_and_query(clip, $urandom_range(0, 10) == 0 ? 34 : $urandom_range(0, 8),
                      $urandom_range(2, 12));
    end

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d requests and %0d results across adds, lookups and clears",
             req_total, rsp_total);
    $display("clip lengths from zero to full scale, tables up to full");
    if (fail_count == 0)
      $display("warp_marker_time_map: match");
    else
      $display("warp_marker_time_map: mismatch");
    $finish;
  end

endmodule

// File: files.f
design/wmtm_pkg.sv
design/wmtm_if.sv
design/wmtm_ram.sv
design/wmtm_front.sv
design/wmtm_muldiv.sv
design/wmtm_back.sv
design/warp_marker_time_map.sv
tb/tb_checker.sv
tb/tb_top.sv
